/* rtl/cfdm_pkg.sv */
// Shared constants, types and calibration tables for the frequency and duty meter.
`default_nettype none
package cfdm_pkg;

    localparam int IN_W   = 32;
    localparam int SUM_W  = 33;
    localparam int REM_W  = 34;
    localparam int FREQ_W = 30;
    localparam int DUTY_W = 23;
    localparam int FQ_BITS = 47;
    localparam int NBANDS = 11;
    localparam int BAND_W = 4;
    localparam int RATIO_W = 32;

    localparam logic [63:0] Bil  = 64'd1000000000;
    localparam logic [63:0] Quad = 64'd1000000000000000;

    typedef enum logic [1:0] {
        STATUS_IN_BAND = 2'd0,
        STATUS_BELOW   = 2'd1,
        STATUS_ABOVE   = 2'd2
    } status_t;

    function automatic logic [63:0] thr(input logic [63:0] i, input logic [63:0] n);
        return (i << 32) + (((n << 32) + Bil - 64'd1) / Bil);
    endfunction

    function automatic logic [63:0] rat(input logic [63:0] h, input logic [63:0] l);
        return ((h << 32) / Bil)
            + ((((h << 32) % Bil) * 64'd1000000 + (l << 32) + Quad / 64'd2) / Quad);
    endfunction

    localparam logic [FQ_BITS-1:0] BAND_EDGE [0:NBANDS] = '{
        FQ_BITS'(thr(64'd0, 64'd50002113)),
        FQ_BITS'(thr(64'd0, 64'd100004248)),
        FQ_BITS'(thr(64'd0, 64'd500021279)),
        FQ_BITS'(thr(64'd1, 64'd42560)),
        FQ_BITS'(thr(64'd5, 64'd213150)),
        FQ_BITS'(thr(64'd10, 64'd426300)),
        FQ_BITS'(thr(64'd50, 64'd2147700)),
        FQ_BITS'(thr(64'd100, 64'd4402000)),
        FQ_BITS'(thr(64'd500, 64'd23743000)),
        FQ_BITS'(thr(64'd1000, 64'd49990000)),
        FQ_BITS'(thr(64'd5000, 64'd500000000)),
        FQ_BITS'(thr(64'd10001, 64'd500000000))
    };

    localparam logic [RATIO_W-1:0] BAND_RATIO [0:NBANDS-1] = '{
        RATIO_W'(rat(64'd999957721, 64'd364754)),
        RATIO_W'(rat(64'd999957469, 64'd723837)),
        RATIO_W'(rat(64'd999957401, 64'd772086)),
        RATIO_W'(rat(64'd999957267, 64'd817571)),
        RATIO_W'(rat(64'd999957371, 64'd812977)),
        RATIO_W'(rat(64'd999956799, 64'd865468)),
        RATIO_W'(rat(64'd999956501, 64'd891733)),
        RATIO_W'(rat(64'd999952514, 64'd254908)),
        RATIO_W'(rat(64'd999950011, 64'd498925)),
        RATIO_W'(rat(64'd999899810, 64'd18998)),
        RATIO_W'(rat(64'd999849922, 64'd511623))
    };

endpackage
`default_nettype wire

/* rtl/capture_frequency_duty_meter_unit.sv */
// Pipelined reciprocal frequency and duty cycle meter top level.
// Pipeline: a start transfer passes one entry stage, 47 restoring divider stages,
// band select, multiply and round; done rises together with the registered result.
// Throughput: one pair per cycle; busy is always low and results are never stalled.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none
module capture_frequency_duty_meter_unit #(
    parameter int CLOCK_HZ  = 200000000,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [cfdm_pkg::IN_W-1:0]      inactive_ticks,
    input  wire logic [cfdm_pkg::IN_W-1:0]      active_ticks,
    output logic                                done,
    output logic [cfdm_pkg::FREQ_W-1:0]         frequency_q16,
    output logic [cfdm_pkg::DUTY_W-1:0]         duty_q16,
    output logic [1:0]                          range_status
);

    localparam int FQ  = cfdm_pkg::FQ_BITS;
    localparam int RW  = cfdm_pkg::REM_W;
    localparam int SW  = cfdm_pkg::SUM_W;
    localparam int QD  = 7 + FRAC_BITS;
    localparam int DW  = 39 + FRAC_BITS;
    localparam logic [63:0] NUM = 64'(CLOCK_HZ) << 32;
    localparam logic [63:0] NUM_TOP = NUM >> FQ;
    localparam logic [63:0] RND = 64'd1 << (31 - FRAC_BITS);
    localparam logic [cfdm_pkg::FREQ_W-1:0] CLAMP_FREQ =
        cfdm_pkg::FREQ_W'(64'd10000 << FRAC_BITS);

    logic          v_reg    [0:FQ];
    logic [SW-1:0] sum_reg  [0:FQ];
    logic          ovf_reg  [0:FQ];
    logic          zero_reg [0:FQ];
    logic [RW-1:0] frem_reg [0:FQ];
    logic [FQ-1:0] fq_reg   [0:FQ];
    logic [RW-1:0] drem_reg [0:FQ];
    logic [QD-1:0] dlow_reg [0:FQ];
    logic [QD-1:0] dq_reg   [0:FQ];

    logic [SW-1:0] sum0;
    logic [38:0]   act100;
    logic [DW-1:0] dnum;

    assign busy   = 1'b0;
    assign sum0   = {1'b0, inactive_ticks} + {1'b0, active_ticks};
    assign act100 = ({7'd0, active_ticks} << 6) + ({7'd0, active_ticks} << 5)
                  + ({7'd0, active_ticks} << 2);
    assign dnum   = (DW'(act100) << FRAC_BITS) + DW'(sum0 >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg[0]  <= sum0;
        ovf_reg[0]  <= ({31'd0, sum0} <= NUM_TOP);
        zero_reg[0] <= (sum0 == '0);
        frem_reg[0] <= RW'(NUM_TOP);
        fq_reg[0]   <= '0;
        drem_reg[0] <= RW'(dnum >> QD);
        dlow_reg[0] <= QD'(dnum);
        dq_reg[0]   <= '0;
    end

    for (genvar k = 1; k <= FQ; k++)
    begin : g_div
        localparam int J = k - 1;
        logic [RW-1:0] ft;
        logic          fge;

        assign ft  = {frem_reg[k-1][RW-2:0], NUM[FQ-1-J]};
        assign fge = (ft >= {1'b0, sum_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            sum_reg[k]  <= sum_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            frem_reg[k] <= fge ? (ft - {1'b0, sum_reg[k-1]}) : ft;
            fq_reg[k]   <= {fq_reg[k-1][FQ-2:0], fge};
        end

        if (J < QD)
        begin : g_duty
            logic [RW-1:0] dt;
            logic          dge;

            assign dt  = {drem_reg[k-1][RW-2:0], dlow_reg[k-1][QD-1]};
            assign dge = (dt >= {1'b0, sum_reg[k-1]});

            always_ff @(posedge clk)
            begin
                drem_reg[k] <= dge ? (dt - {1'b0, sum_reg[k-1]}) : dt;
                dlow_reg[k] <= {dlow_reg[k-1][QD-2:0], 1'b0};
                dq_reg[k]   <= {dq_reg[k-1][QD-2:0], dge};
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                drem_reg[k] <= drem_reg[k-1];
                dlow_reg[k] <= dlow_reg[k-1];
                dq_reg[k]   <= dq_reg[k-1];
            end
        end
    end

    // band select
    logic                                 bv_reg;
    logic [FQ-1:0]                        braw_reg;
    logic [cfdm_pkg::RATIO_W-1:0]         bratio_reg;
    cfdm_pkg::status_t                    bstat_reg;
    logic [cfdm_pkg::DUTY_W-1:0]          bduty_reg;

    logic [FQ-1:0]                        raw;
    logic [cfdm_pkg::BAND_W-1:0]          band;
    cfdm_pkg::status_t                    stat;

    assign raw = fq_reg[FQ];

    always_comb
    begin
        band = '0;
        for (int b = 1; b < cfdm_pkg::NBANDS; b++)
        begin
            if (raw >= cfdm_pkg::BAND_EDGE[b])
            begin
                band = cfdm_pkg::BAND_W'(b);
            end
        end
        if (ovf_reg[FQ] || raw >= cfdm_pkg::BAND_EDGE[cfdm_pkg::NBANDS])
        begin
            stat = cfdm_pkg::STATUS_ABOVE;
        end
        else if (raw < cfdm_pkg::BAND_EDGE[0])
        begin
            stat = cfdm_pkg::STATUS_BELOW;
        end
        else
        begin
            stat = cfdm_pkg::STATUS_IN_BAND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= 1'b0;
        end
        else
        begin
            bv_reg <= v_reg[FQ];
        end
    end

    always_ff @(posedge clk)
    begin
        braw_reg   <= raw;
        bratio_reg <= cfdm_pkg::BAND_RATIO[band];
        bstat_reg  <= stat;
        bduty_reg  <= zero_reg[FQ] ? '0 : cfdm_pkg::DUTY_W'(dq_reg[FQ]);
    end

    // multiply
    logic                             mv_reg;
    logic [FQ-1:0]                    mhi_reg;
    logic [31:0]                      mlo_reg;
    cfdm_pkg::status_t                mstat_reg;
    logic [cfdm_pkg::DUTY_W-1:0]      mduty_reg;
    logic [63:0]                      plo;
    logic [63:0]                      phi;

    assign plo = {32'd0, braw_reg[31:0]} * {32'd0, bratio_reg};
    assign phi = {{(96-FQ){1'b0}}, braw_reg[FQ-1:32]} * {32'd0, bratio_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else
        begin
            mv_reg <= bv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mhi_reg   <= phi[FQ-1:0];
        mlo_reg   <= plo[63:32];
        mstat_reg <= bstat_reg;
        mduty_reg <= bduty_reg;
    end

    // round and drive result
    logic [63:0]                  cal;
    logic [63:0]                  fr;
    logic [cfdm_pkg::FREQ_W-1:0]  freq_next;

    assign cal = {{(64-FQ){1'b0}}, mhi_reg} + {32'd0, mlo_reg};
    assign fr  = (cal + RND) >> (32 - FRAC_BITS);

    always_comb
    begin
        case (mstat_reg)
            cfdm_pkg::STATUS_ABOVE: freq_next = CLAMP_FREQ;
            cfdm_pkg::STATUS_BELOW: freq_next = '0;
            default:                freq_next = cfdm_pkg::FREQ_W'(fr);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        frequency_q16 <= freq_next;
        duty_q16      <= mduty_reg;
        range_status  <= mstat_reg;
    end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the capture frequency and duty meter unit.
`default_nettype none
module tb_top;

    localparam int NRAND = 1300;
    localparam int DRAIN = 60;
    localparam int WDOG_LIMIT = 4000;
    localparam int IN_W = cfdm_pkg::IN_W;
    localparam int FREQ_W = cfdm_pkg::FREQ_W;
    localparam int DUTY_W = cfdm_pkg::DUTY_W;
    localparam int NBANDS = cfdm_pkg::NBANDS;
    localparam logic [63:0] CLK_HZ = 64'd200000000;
    localparam logic [63:0] MAX32 = 64'hFFFFFFFF;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [DUTY_W-1:0]  duty;
        cfdm_pkg::status_t  status;
    } meas_t;

    typedef struct {
        logic [IN_W-1:0] inact;
        logic [IN_W-1:0] act;
        bit              pinned;
        meas_t           res;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [IN_W-1:0]     inactive_ticks = '0;
    logic [IN_W-1:0]     active_ticks = '0;
    logic                busy;
    logic                done;
    logic [FREQ_W-1:0]   frequency_q16;
    logic [DUTY_W-1:0]   duty_q16;
    logic [1:0]          range_status;

    logic [63:0]         edge_q32 [0:NBANDS];
    logic [31:0]         ratio_q32 [0:NBANDS-1];
    meas_t               expected_meas [$];
    bit                  pin_now = 1'b0;
    meas_t               pin_res = '0;
    int                  accept_cnt = 0;
    int                  mismatches = 0;
    int                  idle_pct = 0;
    int                  wdog = 0;

    capture_frequency_duty_meter_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .inactive_ticks(inactive_ticks), .active_ticks(active_ticks),
        .done(done), .frequency_q16(frequency_q16), .duty_q16(duty_q16),
        .range_status(range_status)
    );

    always #1 clk = ~clk;

    function automatic meas_t measure(input logic [IN_W-1:0] inact,
                                      input logic [IN_W-1:0] act);
        meas_t m;
        logic [63:0] period;
        logic [63:0] raw;
        logic [127:0] cal;
        int b;
        m.duty = '0;
        period = 64'(inact) + 64'(act);
        if (period == 0)
        begin
            m.freq = FREQ_W'(64'd10000 << 16);
            m.status = cfdm_pkg::STATUS_ABOVE;
            return m;
        end
        m.duty = DUTY_W'((((64'(act) * 64'd100) << 16) + (period >> 1)) / period);
        raw = (CLK_HZ << 32) / period;
        if (raw >= edge_q32[NBANDS])
        begin
            m.freq = FREQ_W'(64'd10000 << 16);
            m.status = cfdm_pkg::STATUS_ABOVE;
        end
        else if (raw < edge_q32[0])
        begin
            m.freq = '0;
            m.status = cfdm_pkg::STATUS_BELOW;
        end
        else
        begin
            b = NBANDS - 1;
            while (b > 0 && raw < edge_q32[b])
                b--;
            cal = (128'(raw) * 128'(ratio_q32[b])) >> 32;
            m.freq = FREQ_W'((cal + 128'(1 << 15)) >> 16);
            m.status = cfdm_pkg::STATUS_IN_BAND;
        end
        return m;
    endfunction

    initial
    begin
        longint unsigned ip [0:NBANDS] = '{0, 0, 0, 1, 5, 10, 50, 100, 500, 1000, 5000, 10001};
        longint unsigned np [0:NBANDS] = '{50002113, 100004248, 500021279, 42560, 213150,
            426300, 2147700, 4402000, 23743000, 49990000, 500000000, 500000000};
        longint unsigned rh [0:NBANDS-1] = '{999957721, 999957469, 999957401, 999957267,
            999957371, 999956799, 999956501, 999952514, 999950011, 999899810, 999849922};
        longint unsigned rl [0:NBANDS-1] = '{364754, 723837, 772086, 817571, 812977,
            865468, 891733, 254908, 498925, 18998, 511623};
        for (int i = 0; i <= NBANDS; i++)
            edge_q32[i] = (64'(ip[i]) << 32)
                + ((64'(np[i]) << 32) + 64'd999999999) / 64'd1000000000;
        for (int i = 0; i < NBANDS; i++)
            ratio_q32[i] = 32'(((128'(rh[i]) * 128'd1000000 + 128'(rl[i])) * (128'd1 << 32)
                + 128'd500000000000000) / 128'd1000000000000000);
    end

    // compare the oldest expectation, then record a new transfer
    always @(posedge clk)
    begin
        meas_t exp_m;
        if (done)
        begin
            if (expected_meas.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result f=%0d d=%0d s=%0d",
                        frequency_q16, duty_q16, range_status);
            end
            else
            begin
                exp_m = expected_meas.pop_front();
                if (frequency_q16 !== exp_m.freq || duty_q16 !== exp_m.duty
                        || range_status !== exp_m.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp f=%0d d=%0d s=%0d got f=%0d d=%0d s=%0d",
                            exp_m.freq, exp_m.duty, exp_m.status,
                            frequency_q16, duty_q16, range_status);
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            expected_meas.push_back(pin_now ? pin_res : measure(inactive_ticks, active_ticks));
            accept_cnt <= accept_cnt + 1;
        end
        if (rst_n && !done && !(start && !busy))
            wdog <= wdog + 1;
        else
            wdog <= 0;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("capture_frequency_duty_meter_unit: mismatch");
            $finish;
        end
    end

    task automatic send_pair(input logic [IN_W-1:0] inact, input logic [IN_W-1:0] act,
                             input bit pinned, input meas_t res);
        int n;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        n = accept_cnt;
        start <= 1'b1;
        inactive_ticks <= inact;
        active_ticks <= act;
        pin_now <= pinned;
        pin_res <= res;
        do @(negedge clk); while (accept_cnt == n);
    endtask

    initial
    begin
        row_t rows [$];
        logic [63:0] period;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [IN_W-1:0] act;
        int e;
        rows = '{
            '{32'd0, 32'd0, 1'b1,
                '{FREQ_W'(10000 << 16), '0, cfdm_pkg::STATUS_ABOVE}},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                '{'0, DUTY_W'(3276800), cfdm_pkg::STATUS_BELOW}},
            '{32'd1, 32'd0, 1'b1,
                '{FREQ_W'(10000 << 16), '0, cfdm_pkg::STATUS_ABOVE}},
            '{32'd0, 32'd1, 1'b1,
                '{FREQ_W'(10000 << 16), DUTY_W'(6553600), cfdm_pkg::STATUS_ABOVE}},
            '{32'hFFFFFFFF, 32'd0, 1'b1,
                '{'0, '0, cfdm_pkg::STATUS_BELOW}},
            '{32'd0, 32'hFFFFFFFF, 1'b1,
                '{'0, DUTY_W'(6553600), cfdm_pkg::STATUS_BELOW}},
            '{32'd9998, 32'd9999, 1'b0, '0},
            '{32'd9999, 32'd9999, 1'b0, '0},
            '{32'd10000, 32'd10000, 1'b0, '0},
            '{32'd15000, 32'd25000, 1'b0, '0},
            '{32'd100000, 32'd100000, 1'b0, '0},
            '{32'd1000000, 32'd1000000, 1'b0, '0},
            '{32'd2000000, 32'd2000000, 1'b0, '0},
            '{32'd10000000, 32'd10000000, 1'b0, '0},
            '{32'd20000000, 32'd20000000, 1'b0, '0},
            '{32'd99999000, 32'd100000000, 1'b0, '0},
            '{32'd200000000, 32'd200000000, 1'b0, '0},
            '{32'd399983000, 32'd2, 1'b0, '0},
            '{32'd1999915000, 32'd1999915000, 1'b0, '0},
            '{32'd1999916000, 32'd1999916000, 1'b0, '0},
            '{32'd3999830000, 32'd1, 1'b0, '0},
            '{32'h55555555, 32'hAAAAAAAA, 1'b0, '0},
            '{32'd7, 32'd3, 1'b0, '0}
        };
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 14;
        foreach (rows[i])
            send_pair(rows[i].inact, rows[i].act, rows[i].pinned, rows[i].res);
        for (int k = 0; k < NRAND; k++)
        begin
            idle_pct = (k < NRAND / 3) ? 14 : (k < 2 * NRAND / 3) ? 48 : 0;
            if ($urandom_range(9) < 2)
            begin
                send_pair($urandom, $urandom, 1'b0, '0);
            end
            else
            begin
                e = $urandom_range(33, 12);
                if (e == 33)
                    period = 64'h100000000 + 64'($urandom_range(32'hFFFFFFFE, 0));
                else
                    period = 64'($urandom_range(32'((64'd1 << e) - 1), 32'(64'd1 << (e - 1))));
                lo = (period > MAX32) ? period - MAX32 : 64'd0;
                hi = (period > MAX32) ? MAX32 : period;
                act = IN_W'(lo + 64'($urandom_range(32'(hi - lo), 0)));
                send_pair(IN_W'(period - 64'(act)), act, 1'b0, '0);
            end
        end
        start <= 1'b0;
        while (expected_meas.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (mismatches == 0)
            $display("capture_frequency_duty_meter_unit: match");
        else
            $display("capture_frequency_duty_meter_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
